@@ sv/blc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the byte-budget LRU cache.
// No dependencies; imported by the cell, the controller and the top level.
package blc_pkg;

	localparam int KEY_W    = 53;
	localparam int SIZE_W   = 32;
	localparam int HANDLE_W = 32;
	localparam int EVCNT_W  = 5;
	localparam int IN_TDATA_W  = 120;
	localparam int OUT_TDATA_W = 72;

	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_STORE  = 1'b1;

	localparam logic [2:0] ADDR_BUDGET = 3'd0;

	typedef enum logic [1:0] {
		SS_LOOKUP    = 2'd0,
		SS_STORED    = 2'd1,
		SS_REJECTED  = 2'd2,
		SS_DUPLICATE = 2'd3
	} store_status_t;

	// Command broadcast to every cell. Wave commands act as the token passes.
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_MATCH,
		OP_EVICT,
		OP_INSERT,
		OP_AGE,
		OP_PROMOTE
	} cell_op_t;

	typedef struct packed {
		cell_op_t              op;
		logic [KEY_W-1:0]      key;
		logic [SIZE_W-1:0]     size;
		logic [HANDLE_W-1:0]   handle;
	} cell_cmd_t;

	// Wavefront carried from cell to cell, one cell per cycle.
	typedef struct packed {
		logic                  live;
		logic                  hit;
		logic [HANDLE_W-1:0]   handle;
		logic [SIZE_W-1:0]     size;
	} wave_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_MATCH_WAIT,
		S_PROMOTE,
		S_EVICT_CHECK,
		S_EVICT_WAIT,
		S_AGE,
		S_INSERT_GO,
		S_INSERT_WAIT,
		S_RESULT
	} ctrl_state_t;

endpackage

@@ sv/blc_cell.sv @@
`timescale 1ns / 1ps
// One cache slot of the cell chain: key, size, handle, valid and age rank.
// Depends on blc_pkg for the command and wave types.
module blc_cell import blc_pkg::*; #(
	parameter int RANK_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_cmd_t         cmd,
	input  logic [RANK_W-1:0] cmd_rank,
	input  wave_t             wave_in,
	input  logic [RANK_W-1:0] rank_in,
	output wave_t             wave_out,
	output logic [RANK_W-1:0] rank_out
);

	logic                valid_q;
	logic [RANK_W-1:0]   rank_q;
	logic [KEY_W-1:0]    key_q;
	logic [SIZE_W-1:0]   size_q;
	logic [HANDLE_W-1:0] handle_q;
	wave_t               wave_q;
	logic [RANK_W-1:0]   wrank_q;

	logic match_m, evict_m, claim_m;
	wave_t             wave_d;
	logic [RANK_W-1:0] wrank_d;

	assign match_m = valid_q && (key_q == cmd.key);
	assign evict_m = valid_q && (rank_q == cmd_rank);
	assign claim_m = !valid_q && !wave_in.hit;

	always_comb begin
		wave_d  = '0;
		wrank_d = '0;
		if (wave_in.live) begin
			wave_d  = wave_in;
			wrank_d = rank_in;
			unique case (cmd.op)
				OP_MATCH: begin
					if (match_m) begin
						wave_d.hit    = 1'b1;
						wave_d.handle = wave_in.handle | handle_q;
						wrank_d       = rank_in | rank_q;
					end
				end
				OP_EVICT: begin
					if (evict_m) begin
						wave_d.hit  = 1'b1;
						wave_d.size = wave_in.size | size_q;
					end
				end
				OP_INSERT: begin
					if (claim_m) begin
						wave_d.hit = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
			wave_q  <= '0;
			wrank_q <= '0;
		end else begin
			wave_q  <= wave_d;
			wrank_q <= wrank_d;
			unique case (cmd.op)
				OP_AGE: begin
					if (valid_q) begin
						rank_q <= rank_q + RANK_W'(1);
					end
				end
				OP_PROMOTE: begin
					if (valid_q && rank_q < cmd_rank) begin
						rank_q <= rank_q + RANK_W'(1);
					end else if (valid_q && rank_q == cmd_rank) begin
						rank_q <= '0;
					end
				end
				OP_EVICT: begin
					if (wave_in.live && evict_m) begin
						valid_q <= 1'b0;
					end
				end
				OP_INSERT: begin
					if (wave_in.live && claim_m) begin
						valid_q <= 1'b1;
						rank_q  <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_INSERT && wave_in.live && claim_m) begin
			key_q    <= cmd.key;
			size_q   <= cmd.size;
			handle_q <= cmd.handle;
		end
	end

	assign wave_out = wave_q;
	assign rank_out = wrank_q;

endmodule

@@ sv/blc_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the cache: item handshake, wave launch, eviction loop, result register.
// Depends on blc_pkg; drives the command bus of the blc_cell chain.
module blc_ctrl import blc_pkg::*; #(
	parameter int ENTRIES = 16,
	parameter int RANK_W  = 4,
	parameter int CNT_W   = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_func,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic [SIZE_W-1:0]      budget,
	output cell_cmd_t              cmd,
	output logic [RANK_W-1:0]      cmd_rank,
	output logic                   wave_start,
	input  wave_t                  wave_last,
	input  logic [RANK_W-1:0]      rank_last
);

	ctrl_state_t state_q, state_d;
	cell_op_t    op;

	logic                   func_q;
	logic [KEY_W-1:0]       key_q;
	logic [SIZE_W-1:0]      size_q;
	logic                   usable_q;
	logic [HANDLE_W-1:0]    handle_q;
	logic [SIZE_W:0]        held_q;
	logic [SIZE_W-1:0]      total_q;
	logic [CNT_W-1:0]       vcount_q;
	logic [EVCNT_W-1:0]     evicted_q;
	logic                   hit_q;
	logic [HANDLE_W-1:0]    fhandle_q;
	store_status_t          status_q;
	logic [RANK_W-1:0]      prank_q;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	logic full, need, reject, load_out;

	assign full     = (vcount_q == CNT_W'(ENTRIES));
	assign need     = (held_q > {1'b0, budget}) || full;
	assign reject   = (func_q == FUNC_STORE) && (!usable_q || size_q > budget);
	assign load_out = (state_q == S_RESULT) && (!m_tvalid_q || m_tready);

	always_comb begin
		state_d    = state_q;
		op         = OP_IDLE;
		wave_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (reject) begin
					state_d = S_RESULT;
				end else begin
					op         = OP_MATCH;
					wave_start = 1'b1;
					state_d    = S_MATCH_WAIT;
				end
			end
			S_MATCH_WAIT: begin
				op = OP_MATCH;
				if (wave_last.live) begin
					if (func_q == FUNC_LOOKUP) begin
						state_d = wave_last.hit ? S_PROMOTE : S_RESULT;
					end else begin
						state_d = wave_last.hit ? S_RESULT : S_EVICT_CHECK;
					end
				end
			end
			S_PROMOTE: begin
				op      = OP_PROMOTE;
				state_d = S_RESULT;
			end
			S_EVICT_CHECK: begin
				if (need && vcount_q != '0) begin
					op         = OP_EVICT;
					wave_start = 1'b1;
					state_d    = S_EVICT_WAIT;
				end else if (!full) begin
					state_d = S_AGE;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_EVICT_WAIT: begin
				op = OP_EVICT;
				if (wave_last.live) state_d = S_EVICT_CHECK;
			end
			S_AGE: begin
				op      = OP_AGE;
				state_d = S_INSERT_GO;
			end
			S_INSERT_GO: begin
				op         = OP_INSERT;
				wave_start = 1'b1;
				state_d    = S_INSERT_WAIT;
			end
			S_INSERT_WAIT: begin
				op = OP_INSERT;
				if (wave_last.live) state_d = S_RESULT;
			end
			S_RESULT: begin
				if (load_out) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			vcount_q   <= '0;
			total_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_EVICT_WAIT && wave_last.live) begin
				vcount_q <= vcount_q - CNT_W'(1);
			end
			if (state_q == S_INSERT_WAIT && wave_last.live && wave_last.hit) begin
				vcount_q <= vcount_q + CNT_W'(1);
			end
			if (state_q == S_EVICT_CHECK && !(need && vcount_q != '0)) begin
				total_q <= held_q[SIZE_W-1:0];
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			func_q   <= s_func;
			key_q    <= s_tdata[52:0];
			size_q   <= s_tdata[84:53];
			usable_q <= s_tdata[85];
			handle_q <= s_tdata[117:86];
		end
		if (state_q == S_CHECK) begin
			hit_q     <= 1'b0;
			fhandle_q <= '0;
			evicted_q <= '0;
			status_q  <= (func_q == FUNC_LOOKUP) ? SS_LOOKUP : SS_REJECTED;
			held_q    <= {1'b0, total_q} + {1'b0, size_q};
		end
		if (state_q == S_MATCH_WAIT && wave_last.live) begin
			if (func_q == FUNC_LOOKUP) begin
				hit_q     <= wave_last.hit;
				fhandle_q <= wave_last.handle;
				prank_q   <= rank_last;
			end else if (wave_last.hit) begin
				status_q <= SS_DUPLICATE;
			end
		end
		if (state_q == S_EVICT_CHECK && !(need && vcount_q != '0)) begin
			status_q <= SS_STORED;
		end
		if (state_q == S_EVICT_WAIT && wave_last.live) begin
			held_q    <= held_q - {1'b0, wave_last.size};
			evicted_q <= evicted_q + EVCNT_W'(1);
		end
		if (load_out) begin
			m_tdata_q <= {total_q, evicted_q, status_q, fhandle_q, hit_q};
		end
	end

	assign cmd.op     = op;
	assign cmd.key    = key_q;
	assign cmd.size   = size_q;
	assign cmd.handle = handle_q;
	assign cmd_rank   = (state_q == S_PROMOTE) ? prank_q : RANK_W'(vcount_q - CNT_W'(1));

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q <= CNT_W'(ENTRIES))
		else $error("slot count above table size");

	a_stored_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT && status_q == SS_STORED) |-> (total_q <= budget))
		else $error("stored item leaves held bytes above budget");

	a_hit_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT && hit_q) |-> (status_q == SS_LOOKUP))
		else $error("hit reported for a store");

	a_wave_expected: assert property (@(posedge clk) disable iff (!arst_n)
		wave_last.live |-> (state_q == S_MATCH_WAIT || state_q == S_EVICT_WAIT ||
			state_q == S_INSERT_WAIT))
		else $error("wave reached chain end outside a wait state");

endmodule

@@ sv/byte_budget_lru_cache_top.sv @@
`timescale 1ns / 1ps
// Byte-budget LRU cache: ENTRIES slot cells in a chain, one sequencer, one item at a time.
// A search, eviction or insert launches a token at the head of the chain and walks it down every cell.
// A rejected store goes straight to the result; a lookup miss or a held key returns after its search,
// a hit adds a promote step, and a new store adds one token per eviction, an age step and an insert.
// The next item is taken once the result is loaded into the result register, which must be free.
// Reset empties the table, clears the held-byte total and sets the budget to zero.
module byte_budget_lru_cache_top import blc_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// APB configuration port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	// item input
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// tile_key[52:0], entry_size[84:53], entry_usable[85], entry_handle[117:86], zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// func[0]: 0 lookup, 1 store
	input  logic [0:0]             s_tuser,
	// item output
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// hit[0], found_handle[32:1], store_status[34:33], evicted_count[39:35],
	// held_bytes[71:40]
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);

	logic [SIZE_W-1:0] budget_q;
	logic              cfg_wr;

	cell_cmd_t         cmd;
	logic [RANK_W-1:0] cmd_rank;
	logic              wave_start;
	wave_t             wave_bus [ENTRIES+1];
	logic [RANK_W-1:0] rank_bus [ENTRIES+1];

	// Budget register; a write takes effect at the access phase.
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_BUDGET) ? budget_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= '0;
		end else if (cfg_wr && paddr == ADDR_BUDGET) begin
			budget_q <= pwdata;
		end
	end

	// Sequencer: accepts one item, launches tokens, holds the result until taken.
	blc_ctrl #(
		.ENTRIES (ENTRIES),
		.RANK_W  (RANK_W),
		.CNT_W   (CNT_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_func     (s_tuser[0]),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.budget     (budget_q),
		.cmd        (cmd),
		.cmd_rank   (cmd_rank),
		.wave_start (wave_start),
		.wave_last  (wave_bus[ENTRIES]),
		.rank_last  (rank_bus[ENTRIES])
	);

	// Head of the chain: a fresh token with nothing found yet.
	always_comb begin
		wave_bus[0]      = '0;
		wave_bus[0].live = wave_start;
		rank_bus[0]      = '0;
	end

	// Slot cells; each passes the token to its neighbor on the next cycle.
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		blc_cell #(
			.RANK_W (RANK_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.cmd_rank (cmd_rank),
			.wave_in  (wave_bus[i]),
			.rank_in  (rank_bus[i]),
			.wave_out (wave_bus[i+1]),
			.rank_out (rank_bus[i+1])
		);
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for byte_budget_lru_cache_top: stream items in, replies out, budget over APB.
// Depends on blc_pkg and the cache top level only; keeps its own mirror of the cache for checking.
module tb_top;
	import blc_pkg::*;

	localparam int SLOTS        = 16;
	localparam int RESET_CYCLES = 10;
	localparam int MAX_GAP      = 12;
	localparam int LONG_HOLD    = 600;
	// Slowest store evicts the whole table; wait on past the last reply at the end to catch strays.
	localparam int DRAIN_CYCLES = 400;
	localparam int KEY_POOL     = 24;
	localparam int PHASES       = 6;

	localparam logic [KEY_W-1:0] KEY_MAX = '1;

	// Budgets walked by the random phases; the last phase draws one at random.
	localparam logic [31:0] PHASE_BUDGETS [PHASES] =
		'{32'd64, 32'd4000, 32'hFFFF_FFFF, 32'd0, 32'd700, 32'd0};
	localparam int PHASE_ITEMS [PHASES] = '{260, 260, 260, 120, 300, 300};

	typedef struct packed {
		logic                func;
		logic [KEY_W-1:0]    key;
		logic [SIZE_W-1:0]   size;
		logic                usable;
		logic [HANDLE_W-1:0] handle;
	} cache_req_t;

	typedef struct packed {
		logic                hit;
		logic [HANDLE_W-1:0] handle;
		store_status_t       status;
		logic [EVCNT_W-1:0]  evicted;
		logic [SIZE_W-1:0]   held;
	} cache_reply_t;

	typedef enum logic {ROW_ITEM, ROW_BUDGET} row_kind_t;

	// One line of the directed script: either a budget write or an item, the latter
	// optionally with its reply spelled out by hand.
	typedef struct {
		row_kind_t    kind;
		logic [31:0]  budget;
		cache_req_t   req;
		logic         typed;
		cache_reply_t reply;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [2:0]             paddr;
	logic [31:0]            pwdata;
	logic [31:0]            prdata;
	logic                   pready;
	logic                   s_tvalid;
	logic                   s_tready;
	// tile_key[52:0], entry_size[84:53], entry_usable[85], entry_handle[117:86], zero pad
	logic [IN_TDATA_W-1:0]  s_tdata;
	// func[0]
	logic [0:0]             s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	// hit[0], found_handle[32:1], store_status[34:33], evicted_count[39:35], held_bytes[71:40]
	logic [OUT_TDATA_W-1:0] m_tdata;

	// Mirror of the cache contents. Reset happens once, so declaration values stand in for it.
	logic              mirror_valid  [SLOTS] = '{default: 1'b0};
	logic [KEY_W-1:0]  mirror_key    [SLOTS];
	logic [SIZE_W-1:0] mirror_size   [SLOTS];
	logic [31:0]       mirror_handle [SLOTS];
	int                mirror_rank   [SLOTS] = '{default: 0};
	logic [31:0]       mirror_held   = '0;
	logic [31:0]       mirror_budget = '0;

	cache_reply_t replies_due [$];
	stim_row_t    directed_rows [$];

	// Set by the sender before each item is offered, read by the monitor on acceptance.
	logic         offered_is_typed = 1'b0;
	cache_reply_t offered_reply    = '0;
	bit           sender_rush      = 1'b0;

	int errors;
	int items_accepted, lookups_seen, hits_seen, stored_seen, rejected_seen, dup_seen;
	int evictions_seen, budget_writes;

	cache_req_t   seen_req;
	cache_reply_t predicted, want, got;

	byte_budget_lru_cache_top #(.ENTRIES(SLOTS)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	// Hard stop: far beyond the slowest legal run (every store evicting the whole table,
	// every gap and stall at its longest, plus the long receiver holds).
	initial begin
		#40_000_000;
		$display("tb_top failed");
		$finish;
	end

	function automatic int first_free_slot();
		for (int i = 0; i < SLOTS; i++)
			if (!mirror_valid[i])
				return i;
		return -1;
	endfunction

	// Advance the mirror by one item and return the reply the cache owes for it.
	function automatic cache_reply_t cache_mirror_step(input cache_req_t r);
		cache_reply_t rep;
		int           slot;
		int           lru;
		int           i;
		logic [32:0]  need_bytes;
		rep  = '0;
		slot = -1;
		for (i = 0; i < SLOTS; i++)
			if (slot < 0 && mirror_valid[i] && mirror_key[i] == r.key)
				slot = i;
		if (r.func == FUNC_LOOKUP) begin
			if (slot >= 0) begin
				// Promote: everything younger than the hit slot ages by one.
				for (i = 0; i < SLOTS; i++)
					if (mirror_valid[i] && i != slot && mirror_rank[i] < mirror_rank[slot])
						mirror_rank[i]++;
				mirror_rank[slot] = 0;
				rep.hit    = 1'b1;
				rep.handle = mirror_handle[slot];
			end
		end else if (!r.usable || r.size > mirror_budget) begin
			rep.status = SS_REJECTED;
		end else if (slot >= 0) begin
			rep.status = SS_DUPLICATE;
		end else begin
			need_bytes = {1'b0, mirror_held} + {1'b0, r.size};
			// Drop the oldest entry until the bytes fit and a slot is free.
			while (need_bytes > {1'b0, mirror_budget} || first_free_slot() < 0) begin
				lru = -1;
				for (i = 0; i < SLOTS; i++)
					if (mirror_valid[i] && (lru < 0 || mirror_rank[i] > mirror_rank[lru]))
						lru = i;
				if (lru < 0)
					break;
				need_bytes        = need_bytes - {1'b0, mirror_size[lru]};
				mirror_valid[lru] = 1'b0;
				rep.evicted       = rep.evicted + 5'd1;
			end
			slot = first_free_slot();
			if (slot >= 0) begin
				for (i = 0; i < SLOTS; i++)
					if (mirror_valid[i])
						mirror_rank[i]++;
				mirror_valid[slot]  = 1'b1;
				mirror_key[slot]    = r.key;
				mirror_size[slot]   = r.size;
				mirror_handle[slot] = r.handle;
				mirror_rank[slot]   = 0;
			end
			mirror_held = need_bytes[31:0];
			rep.status  = SS_STORED;
		end
		rep.held = mirror_held;
		return rep;
	endfunction

	task automatic check_field(input string what, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, exp_v, act_v);
		end
	endtask

	function automatic void add_item_row(input cache_req_t r, input logic typed,
			input cache_reply_t rep);
		stim_row_t row;
		row.kind   = ROW_ITEM;
		row.budget = '0;
		row.req    = r;
		row.typed  = typed;
		row.reply  = rep;
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	function automatic void add_budget_row(input logic [31:0] value);
		stim_row_t row;
		row.kind   = ROW_BUDGET;
		row.budget = value;
		row.req    = '0;
		row.typed  = 1'b0;
		row.reply  = '0;
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	// Write the budget, then read it back. Entered and left at a falling edge.
	task automatic write_budget(input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_BUDGET;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		// Hold psel, drop to a read setup.
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		check_field("byte_budget readback", value, prdata);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Play one row. Item rows return at the falling edge after acceptance with
	// s_tvalid still high, so a back-to-back item keeps valid up without a dip.
	task automatic apply_row(input stim_row_t row);
		int gap;
		if (row.kind == ROW_BUDGET) begin
			s_tvalid <= 1'b0;
			// One reply per item, so an empty queue means the cache is idle.
			while (replies_due.size() != 0) @(negedge clk);
			write_budget(row.budget);
		end else begin
			if ($urandom_range(0, 39) == 0)
				sender_rush = !sender_rush;
			gap = sender_rush ? 0 : $urandom_range(0, MAX_GAP);
			offered_is_typed = row.typed;
			offered_reply    = row.reply;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			s_tvalid <= 1'b1;
			s_tuser  <= row.req.func;
			s_tdata  <= {2'b00, row.req.handle, row.req.usable, row.req.size, row.req.key};
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			@(negedge clk);
		end
	endtask

	// Monitor: budget writes and accepted items feed the mirror; every reply is
	// compared against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == ADDR_BUDGET) begin
				mirror_budget = pwdata;
				budget_writes++;
			end
			if (s_tvalid && s_tready) begin
				seen_req.func   = s_tuser[0];
				seen_req.key    = s_tdata[52:0];
				seen_req.size   = s_tdata[84:53];
				seen_req.usable = s_tdata[85];
				seen_req.handle = s_tdata[117:86];
				predicted = cache_mirror_step(seen_req);
				replies_due.insert(replies_due.size(),
					offered_is_typed ? offered_reply : predicted);
				items_accepted++;
				if (seen_req.func == FUNC_LOOKUP) begin
					lookups_seen++;
					if (predicted.hit) hits_seen++;
				end
				case (predicted.status)
					SS_STORED:    stored_seen++;
					SS_REJECTED:  rejected_seen++;
					SS_DUPLICATE: dup_seen++;
					default: ;
				endcase
				evictions_seen += int'(predicted.evicted);
			end
			if (m_tvalid && m_tready) begin
				got.hit     = m_tdata[0];
				got.handle  = m_tdata[32:1];
				got.status  = store_status_t'(m_tdata[34:33]);
				got.evicted = m_tdata[39:35];
				got.held    = m_tdata[71:40];
				if (replies_due.size() == 0) begin
					errors++;
					$display("%0t: reply with nothing expected, expected none, got 0x%0h",
						$time, m_tdata);
				end else begin
					want = replies_due.pop_front();
					check_field("hit", 32'(want.hit), 32'(got.hit));
					check_field("found_handle", want.handle, got.handle);
					check_field("store_status", 32'(want.status), 32'(got.status));
					check_field("evicted_count", 32'(want.evicted), 32'(got.evicted));
					check_field("held_bytes", want.held, got.held);
				end
			end
		end
	end

	// Reply sink: random stalls, bursts of none, and two long holds that back the
	// cache up until it stops taking items.
	initial begin : reply_sink
		int stall;
		int taken;
		bit rush;
		m_tready = 1'b0;
		taken    = 0;
		rush     = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rush = !rush;
			stall = rush ? 0 : $urandom_range(0, MAX_GAP);
			if (taken == 150 || taken == 700)
				stall = LONG_HOLD;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			taken++;
			@(negedge clk);
		end
	end

	initial begin : stimulus
		stim_row_t        row;
		cache_req_t       r;
		logic [KEY_W-1:0] key_pool [KEY_POOL];
		logic [63:0]      wide;
		logic [31:0]      budget;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;

		// Directed script. Budget is zero out of reset: only zero-sized stores get in.
		add_item_row('{FUNC_LOOKUP, '0, 32'd0, 1'b0, 32'd0}, 1'b1,
			'{1'b0, 32'd0, SS_LOOKUP, 5'd0, 32'd0});
		add_item_row('{FUNC_STORE, KEY_MAX, 32'd0, 1'b1, 32'hFFFF_FFFF}, 1'b1,
			'{1'b0, 32'd0, SS_STORED, 5'd0, 32'd0});
		add_item_row('{FUNC_STORE, 53'd1, 32'd1, 1'b1, 32'h1234_5678}, 1'b1,
			'{1'b0, 32'd0, SS_REJECTED, 5'd0, 32'd0});
		add_item_row('{FUNC_STORE, 53'd2, 32'd0, 1'b0, 32'h0BAD_F00D}, 1'b1,
			'{1'b0, 32'd0, SS_REJECTED, 5'd0, 32'd0});
		add_item_row('{FUNC_LOOKUP, KEY_MAX, 32'hFFFF_FFFF, 1'b1, 32'd0}, 1'b1,
			'{1'b1, 32'hFFFF_FFFF, SS_LOOKUP, 5'd0, 32'd0});
		add_item_row('{FUNC_STORE, KEY_MAX, 32'd0, 1'b1, 32'd7}, 1'b1,
			'{1'b0, 32'd0, SS_DUPLICATE, 5'd0, 32'd0});
		// Widest budget: a full-size entry fits, one more byte pushes both entries out.
		add_budget_row(32'hFFFF_FFFF);
		add_item_row('{FUNC_STORE, '0, 32'hFFFF_FFFF, 1'b1, 32'd0}, 1'b1,
			'{1'b0, 32'd0, SS_STORED, 5'd0, 32'hFFFF_FFFF});
		add_item_row('{FUNC_STORE, 53'd3, 32'd1, 1'b1, 32'hA5A5_0003}, 1'b1,
			'{1'b0, 32'd0, SS_STORED, 5'd2, 32'd1});
		// Fill the table, then overflow it by one slot while far under budget.
		for (int k = 16; k < 31; k++)
			add_item_row('{FUNC_STORE, 53'(k), 32'd1, 1'b1, $urandom()}, 1'b0, '0);
		add_item_row('{FUNC_STORE, 53'd31, 32'd1, 1'b1, $urandom()}, 1'b1,
			'{1'b0, 32'd0, SS_STORED, 5'd1, 32'd16});
		add_item_row('{FUNC_LOOKUP, 53'd3, 32'd0, 1'b0, 32'd0}, 1'b1,
			'{1'b0, 32'd0, SS_LOOKUP, 5'd0, 32'd16});
		add_item_row('{FUNC_LOOKUP, 53'd16, 32'd0, 1'b0, 32'd0}, 1'b0, '0);
		// Lower the budget under the held total; the next store does the trimming.
		add_budget_row(32'd4);
		add_item_row('{FUNC_STORE, 53'd40, 32'd2, 1'b1, $urandom()}, 1'b0, '0);
		add_item_row('{FUNC_STORE, 53'd41, 32'd5, 1'b1, $urandom()}, 1'b1,
			'{1'b0, 32'd0, SS_REJECTED, 5'd0, 32'd4});

		// Reset once, released at a falling edge.
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			apply_row(directed_rows[i]);

		// Random phases: each sets a budget, then mixes lookups and stores over a
		// small key pool so hits, duplicates and evictions come often.
		for (int p = 0; p < PHASES; p++) begin
			budget = (p == PHASES - 1) ? $urandom() : PHASE_BUDGETS[p];
			row.kind   = ROW_BUDGET;
			row.budget = budget;
			row.req    = '0;
			row.typed  = 1'b0;
			row.reply  = '0;
			apply_row(row);
			for (int k = 0; k < KEY_POOL; k++) begin
				wide        = {$urandom(), $urandom()};
				key_pool[k] = wide[KEY_W-1:0];
			end
			row.kind = ROW_ITEM;
			for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
				wide     = {$urandom(), $urandom()};
				r.func   = ($urandom_range(0, 1) == 1) ? FUNC_STORE : FUNC_LOOKUP;
				r.key    = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
					: wide[KEY_W-1:0];
				r.usable = ($urandom_range(0, 9) != 0);
				r.handle = $urandom();
				case ($urandom_range(0, 9))
					0:       r.size = '0;
					1:       r.size = $urandom();
					2:       r.size = $urandom_range(0, budget);
					default: r.size = $urandom_range(0, budget / 6 + 1);
				endcase
				row.req = r;
				apply_row(row);
			end
		end

		// Drain: stop offering, collect every reply, then watch for strays.
		s_tvalid <= 1'b0;
		while (replies_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Ran %0d items: %0d lookups (%0d hits), %0d stored, %0d rejected, %0d duplicate",
			items_accepted, lookups_seen, hits_seen, stored_seen, rejected_seen, dup_seen);
		$display("%0d entries evicted across %0d budget settings; %0d mismatches",
			evictions_seen, budget_writes, errors);
		if (errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
